/* rtl/core/sirt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sirt_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ID_BITS     = 12;
   localparam int VAL_W       = 32;
   localparam int CNT_VAL_W   = 16;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W     = ID_BITS + VAL_W;
   localparam int CIDX_W      = ID_BITS + 1;
   localparam int CNT_DEPTH   = 2 ** CIDX_W;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_REMAP = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_MISS  = 3'd1,
      ST_RANGE = 3'd2,
      ST_EMPTY = 3'd3,
      ST_FULL  = 3'd4
   } status_type;

   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_SWEEP     = 10'b00_0000_0010,
      S_SRCH_RD   = 10'b00_0000_0100,
      S_SRCH_CMP  = 10'b00_0000_1000,
      S_PROBE_CMP = 10'b00_0001_0000,
      S_SHIFT     = 10'b00_0010_0000,
      S_INSERT    = 10'b00_0100_0000,
      S_CNT_RD    = 10'b00_1000_0000,
      S_FINISH    = 10'b01_0000_0000,
      S_SPARE     = 10'b10_0000_0000
   } state_type;

endpackage
`default_nettype wire

/* rtl/core/sirt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module sirt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/core/sorted_id_remap_table_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Remap: a bisection over the loaded entries, a probe of the slot found and, on a miss,
// a counter update; ID zero or an empty table skips the search. Load: bisection, shift, insert.
// Read: counter read only. One request at a time; each bisection step is a read then
// a compare on the single-port-read table memory. Clear sweeps 8192 counter words.
// Reset: synchronous; the table empties and a clearing pass over the 8192 counter words
// runs with req_stall high.
module sorted_id_remap_table_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_op,
   input  wire logic [sirt_pkg::ID_BITS-1:0]     req_old_id,
   input  wire logic [sirt_pkg::VAL_W-1:0]       req_new_id_in,
   input  wire logic                             req_kind,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [sirt_pkg::VAL_W-1:0]            rsp_new_id,
   output logic [2:0]                            rsp_status,
   output logic                                  rsp_first_miss,
   output logic [sirt_pkg::CNT_VAL_W-1:0]        rsp_miss_count
);
   import sirt_pkg::*;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [ID_BITS-1:0]     id_ff, id_in;
   logic [VAL_W-1:0]       val_ff, val_in;
   logic                   kind_ff, kind_in;
   logic [FILL_W-1:0]      lo_ff, lo_in, hi_ff, hi_in, sh_ff, sh_in;
   logic                   pend_ff, pend_in;
   logic [ADDR_W-1:0]      pend_addr_ff, pend_addr_in;
   logic [FILL_W-1:0]      count_ff, count_in;
   logic [ID_BITS-1:0]     largest_ff, largest_in;
   logic [CIDX_W-1:0]      sweep_ff, sweep_in;
   logic                   boot_ff, boot_in;
   // staged result
   logic [VAL_W-1:0]       res_id_ff, res_id_in;
   status_type             res_st_ff, res_st_in;
   logic                   res_first_ff, res_first_in;
   logic [CNT_VAL_W-1:0]   res_cnt_ff, res_cnt_in;
   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [2:0]             rsp_st_ff, rsp_st_in;
   logic                   rsp_first_ff, rsp_first_in;
   logic [CNT_VAL_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   // memory ports
   logic                   tbl_we;
   logic [ADDR_W-1:0]      tbl_waddr, tbl_raddr;
   logic [ENTRY_W-1:0]     tbl_wdata, tbl_rdata;
   logic                   cnt_we;
   logic [CIDX_W-1:0]      cnt_waddr, cnt_raddr;
   logic [CNT_VAL_W-1:0]   cnt_wdata, cnt_rdata;

   logic [FILL_W-1:0]      mid;
   logic [ID_BITS-1:0]     rd_key;
   logic [VAL_W-1:0]       rd_val;
   logic                   go_right;
   logic                   req_fire;

   sirt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   sirt_ram #(.WIDTH(CNT_VAL_W), .DEPTH(CNT_DEPTH)) u_counters (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rd_key    = tbl_rdata[ENTRY_W-1:VAL_W];
   assign rd_val    = tbl_rdata[VAL_W-1:0];
   // load searches for the slot after equal keys, remap for the first equal key
   assign go_right  = (op_ff == OP_LOAD) ? (rd_key <= id_ff) : (rd_key < id_ff);

   // counter address comes straight from the request while idle (read op)
   assign cnt_raddr = (state_ff == S_IDLE) ? {req_kind, req_old_id} : {kind_ff, id_ff};

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      val_in       = val_ff;
      kind_in      = kind_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      sh_in        = sh_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      count_in     = count_ff;
      largest_in   = largest_ff;
      sweep_in     = sweep_ff;
      boot_in      = boot_ff;
      res_id_in    = res_id_ff;
      res_st_in    = res_st_ff;
      res_first_in = res_first_ff;
      res_cnt_in   = res_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_id_in    = rsp_id_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_first_in = rsp_first_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      tbl_we       = 1'b0;
      tbl_waddr    = pend_addr_ff;
      tbl_wdata    = tbl_rdata;
      tbl_raddr    = mid[ADDR_W-1:0];
      cnt_we       = 1'b0;
      cnt_waddr    = sweep_ff;
      cnt_wdata    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in        = op_type'(req_op);
               id_in        = req_old_id;
               val_in       = req_new_id_in;
               kind_in      = req_kind;
               res_id_in    = '0;
               res_st_in    = ST_OK;
               res_first_in = 1'b0;
               res_cnt_in   = '0;
               lo_in        = '0;
               hi_in        = count_ff;
               unique case (op_type'(req_op))
                  OP_CLEAR: begin
                     count_in   = '0;
                     largest_in = '0;
                     sweep_in   = '0;
                     state_in   = S_SWEEP;
                  end
                  OP_LOAD: begin
                     if (count_ff == FILL_W'(TABLE_DEPTH)) begin
                        res_st_in = ST_FULL;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_SRCH_RD;
                     end
                  end
                  OP_REMAP: begin
                     if (req_old_id == '0) begin
                        state_in = S_FINISH;
                     end else if (count_ff == '0) begin
                        res_st_in = ST_EMPTY;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_SRCH_RD;
                     end
                  end
                  default: begin
                     state_in = S_CNT_RD;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            cnt_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == CIDX_W'(CNT_DEPTH - 1)) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? S_IDLE : S_FINISH;
            end
         end
         S_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               state_in = S_SRCH_CMP;
            end else if (op_ff == OP_LOAD) begin
               sh_in    = count_ff;
               pend_in  = 1'b0;
               state_in = S_SHIFT;
            end else if (lo_ff < count_ff) begin
               tbl_raddr = lo_ff[ADDR_W-1:0];
               state_in  = S_PROBE_CMP;
            end else if (id_ff > largest_ff) begin
               res_st_in = ST_RANGE;
               state_in  = S_FINISH;
            end else begin
               state_in = S_CNT_RD;
            end
         end
         S_SRCH_CMP: begin
            if (go_right) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
            state_in = S_SRCH_RD;
         end
         S_PROBE_CMP: begin
            if (rd_key == id_ff && rd_val != '0) begin
               res_id_in = rd_val;
               state_in  = S_FINISH;
            end else if (id_ff > largest_ff) begin
               res_st_in = ST_RANGE;
               state_in  = S_FINISH;
            end else begin
               state_in = S_CNT_RD;
            end
         end
         S_SHIFT: begin
            // read index sh-1, write it one slot up in the next cycle
            tbl_we    = pend_ff;
            tbl_raddr = ADDR_W'(sh_ff - 1'b1);
            if (sh_ff != lo_ff) begin
               pend_in      = 1'b1;
               pend_addr_in = sh_ff[ADDR_W-1:0];
               sh_in        = sh_ff - 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            tbl_we    = 1'b1;
            tbl_waddr = lo_ff[ADDR_W-1:0];
            tbl_wdata = {id_ff, val_ff};
            count_in  = count_ff + 1'b1;
            if (id_ff > largest_ff) begin
               largest_in = id_ff;
            end
            state_in = S_FINISH;
         end
         S_CNT_RD: begin
            if (op_ff == OP_READ) begin
               res_cnt_in = cnt_rdata;
            end else begin
               cnt_we       = 1'b1;
               cnt_waddr    = {kind_ff, id_ff};
               cnt_wdata    = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
               res_cnt_in   = cnt_wdata;
               res_first_in = (cnt_rdata == '0);
               res_st_in    = ST_MISS;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = res_id_ff;
               rsp_st_in    = res_st_ff;
               rsp_first_in = res_first_ff;
               rsp_cnt_in   = res_cnt_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         boot_ff      <= 1'b1;
         count_ff     <= '0;
         largest_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         boot_ff      <= boot_in;
         count_ff     <= count_in;
         largest_ff   <= largest_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      id_ff        <= id_in;
      val_ff       <= val_in;
      kind_ff      <= kind_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      sh_ff        <= sh_in;
      pend_addr_ff <= pend_addr_in;
      res_id_ff    <= res_id_in;
      res_st_ff    <= res_st_in;
      res_first_ff <= res_first_in;
      res_cnt_ff   <= res_cnt_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_first_ff <= rsp_first_in;
      rsp_cnt_ff   <= rsp_cnt_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_id     = rsp_id_ff;
   assign rsp_status     = rsp_st_ff;
   assign rsp_first_miss = rsp_first_ff;
   assign rsp_miss_count = rsp_cnt_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FILL_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_cnt_write_state: assert property (@(posedge clock) disable iff (reset)
      cnt_we |-> (state_ff == S_SWEEP || state_ff == S_CNT_RD))
      else $error("counter write outside sweep or update");

   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && tbl_we) |-> (tbl_waddr == ADDR_W'(sh_ff + 1'b1)))
      else $error("shift write not one slot above read");

   a_first_has_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_first_miss) |-> (rsp_miss_count == 16'd1
         && rsp_status == ST_MISS))
      else $error("first miss without count of one");

   a_found_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_new_id != '0) |-> (rsp_status == ST_OK))
      else $error("mapped id with non-ok status");
endmodule
`default_nettype wire

/* bench/tb_sorted_id_remap_table_unit.sv */
`timescale 1ns / 1ps
module tb_sorted_id_remap_table_unit;
   import sirt_pkg::*;

   // One request into the block and the result it must produce.
   typedef struct {
      op_type            op;
      logic [ID_BITS-1:0] id;
      logic [VAL_W-1:0]  val;
      logic              kind;
   } remap_req_type;

   typedef struct {
      logic [VAL_W-1:0]     new_id;
      status_type           status;
      logic                 first;
      logic [CNT_VAL_W-1:0] count;
   } remap_rsp_type;

   // Directed row: typed rows carry their expected result, the rest use the predictor.
   typedef struct {
      op_type      op;
      int          id;
      logic [31:0] val;
      bit          kind;
      bit          typed;
      logic [31:0] e_id;
      status_type  e_st;
      bit          e_first;
      int          e_cnt;
   } vector_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   wire  req_stall;
   logic [1:0] req_op = 2'd0;
   logic [ID_BITS-1:0] req_old_id = '0;
   logic [VAL_W-1:0] req_new_id_in = '0;
   logic req_kind = 1'b0;
   wire  rsp_valid;
   logic rsp_stall = 1'b0;
   wire  [VAL_W-1:0] rsp_new_id;
   wire  [2:0] rsp_status;
   wire  rsp_first_miss;
   wire  [CNT_VAL_W-1:0] rsp_miss_count;

   sorted_id_remap_table_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_old_id(req_old_id), .req_new_id_in(req_new_id_in), .req_kind(req_kind),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_new_id(rsp_new_id),
      .rsp_status(rsp_status), .rsp_first_miss(rsp_first_miss),
      .rsp_miss_count(rsp_miss_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the table, kept sorted by old ID, and of the miss counters.
   logic [ID_BITS-1:0]   shadow_key [TABLE_DEPTH];
   logic [VAL_W-1:0]     shadow_val [TABLE_DEPTH];
   logic [CNT_VAL_W-1:0] miss_tally [CNT_DEPTH];
   int                   fill_level = 0;
   int                   top_key = 0;

   remap_rsp_type pending_rsp[$];
   int            error_count = 0;
   bit            hold_long = 1'b0;

   // Applies one request to the shadow state and returns the result it should give.
   function automatic remap_rsp_type apply_request(remap_req_type r);
      remap_rsp_type o;
      int lo, hi, mid, cidx;
      o = '{new_id: '0, status: ST_OK, first: 1'b0, count: '0};
      cidx = int'(r.kind) * (1 << ID_BITS) + int'(r.id);
      case (r.op)
         OP_CLEAR: begin
            fill_level = 0;
            top_key = 0;
            foreach (miss_tally[i]) miss_tally[i] = '0;
         end
         OP_LOAD: begin
            if (fill_level >= TABLE_DEPTH) begin
               o.status = ST_FULL;
            end else begin
               // insert after any equal keys
               lo = 0;
               hi = fill_level;
               while (lo < hi) begin
                  mid = (lo + hi) / 2;
                  if (shadow_key[mid] <= r.id) lo = mid + 1;
                  else hi = mid;
               end
               for (int i = fill_level; i > lo; i--) begin
                  shadow_key[i] = shadow_key[i-1];
                  shadow_val[i] = shadow_val[i-1];
               end
               shadow_key[lo] = r.id;
               shadow_val[lo] = r.val;
               fill_level++;
               if (int'(r.id) > top_key) top_key = int'(r.id);
            end
         end
         OP_REMAP: begin
            if (r.id == '0) begin
               o.status = ST_OK;
            end else if (fill_level == 0) begin
               o.status = ST_EMPTY;
            end else begin
               // first entry with an equal key
               lo = 0;
               hi = fill_level;
               while (lo < hi) begin
                  mid = (lo + hi) / 2;
                  if (shadow_key[mid] < r.id) lo = mid + 1;
                  else hi = mid;
               end
               if (lo < fill_level && shadow_key[lo] == r.id) o.new_id = shadow_val[lo];
               // a zero new ID is treated like an absent key
               if (o.new_id == '0) begin
                  if (int'(r.id) > top_key) begin
                     o.status = ST_RANGE;
                  end else begin
                     o.first = (miss_tally[cidx] == '0);
                     if (miss_tally[cidx] != '1) miss_tally[cidx] = miss_tally[cidx] + 1'b1;
                     o.count = miss_tally[cidx];
                     o.status = ST_MISS;
                  end
               end
            end
         end
         default: begin
            o.count = miss_tally[cidx];
         end
      endcase
      return o;
   endfunction

   // Offers one request after a random gap; predicts once it is accepted.
   task automatic send_request(input remap_req_type r, input bit typed,
                               input remap_rsp_type want);
      int gap;
      remap_rsp_type p;
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= r.op;
      req_old_id <= r.id;
      req_new_id_in <= r.val;
      req_kind <= r.kind;
      do @(posedge clock); while (req_stall);
      p = apply_request(r);
      pending_rsp.push_back(typed ? want : p);
   endtask

   task automatic send_plain(input op_type op, input int id, input logic [31:0] val,
                             input bit kind);
      remap_req_type r;
      remap_rsp_type none;
      r = '{op: op, id: id[ID_BITS-1:0], val: val, kind: kind};
      none = '{new_id: '0, status: ST_OK, first: 1'b0, count: '0};
      send_request(r, 1'b0, none);
   endtask

   // A burst of loads into a key window, then a random mix; the caller clears the table first.
   task automatic random_batch(input int n);
      int key_hi, loads, k, id;
      key_hi = ($urandom_range(0, 2) == 0) ? 15 : (($urandom_range(0, 1) == 0) ? 255 : 4095);
      loads = $urandom_range(1, 40);
      for (int i = 0; i < loads; i++) begin
         id = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, key_hi);
         send_plain(OP_LOAD, id, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom(),
                    1'($urandom_range(0, 1)));
      end
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, key_hi);
         if (k < 55) send_plain(OP_REMAP, id, $urandom(), 1'($urandom_range(0, 1)));
         else if (k < 75) send_plain(OP_READ, id, $urandom(), 1'($urandom_range(0, 1)));
         else if (k < 92)
            send_plain(OP_LOAD, id, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom(),
                       1'($urandom_range(0, 1)));
         else send_plain(OP_REMAP, 0, $urandom(), 1'($urandom_range(0, 1)));
      end
   endtask

   vector_row_type vectors [24] = '{
      // empty table after reset
      '{OP_REMAP,    5, 32'h0,        0, 1, 32'h0,        ST_EMPTY, 0, 0},
      '{OP_READ,     5, 32'h0,        0, 1, 32'h0,        ST_OK,    0, 0},
      '{OP_REMAP,    0, 32'hFFFFFFFF, 1, 1, 32'h0,        ST_OK,    0, 0},
      // loads: duplicate key, max key, zero new ID
      '{OP_LOAD,   100, 32'hFFFFFFFF, 0, 1, 32'h0,        ST_OK,    0, 0},
      '{OP_LOAD,  4095, 32'h12345678, 1, 1, 32'h0,        ST_OK,    0, 0},
      '{OP_LOAD,   100, 32'h0000000A, 0, 1, 32'h0,        ST_OK,    0, 0},
      '{OP_LOAD,    50, 32'h0,        0, 1, 32'h0,        ST_OK,    0, 0},
      '{OP_REMAP,  100, 32'h0,        0, 1, 32'hFFFFFFFF, ST_OK,    0, 0},
      '{OP_REMAP, 4095, 32'h0,        1, 1, 32'h12345678, ST_OK,    0, 0},
      // zero new ID counts as a miss
      '{OP_REMAP,   50, 32'h0,        1, 1, 32'h0,        ST_MISS,  1, 1},
      '{OP_REMAP,   50, 32'h0,        1, 1, 32'h0,        ST_MISS,  0, 2},
      '{OP_REMAP,   60, 32'h0,        0, 1, 32'h0,        ST_MISS,  1, 1},
      '{OP_READ,    50, 32'h0,        1, 1, 32'h0,        ST_OK,    0, 2},
      '{OP_READ,    50, 32'h0,        0, 1, 32'h0,        ST_OK,    0, 0},
      '{OP_CLEAR,    0, 32'h0,        0, 1, 32'h0,        ST_OK,    0, 0},
      // above largest key
      '{OP_LOAD,     7, 32'h1,        0, 1, 32'h0,        ST_OK,    0, 0},
      '{OP_REMAP,    8, 32'h0,        0, 1, 32'h0,        ST_RANGE, 0, 0},
      '{OP_REMAP, 4095, 32'h0,        1, 1, 32'h0,        ST_RANGE, 0, 0},
      '{OP_REMAP,    3, 32'h0,        0, 1, 32'h0,        ST_MISS,  1, 1},
      '{OP_READ,     3, 32'h0,        0, 1, 32'h0,        ST_OK,    0, 1},
      '{OP_LOAD,     0, 32'h5,        1, 0, 32'h0,        ST_OK,    0, 0},
      '{OP_REMAP,    0, 32'h0,        0, 1, 32'h0,        ST_OK,    0, 0},
      '{OP_REMAP,    7, 32'h0,        1, 0, 32'h0,        ST_OK,    0, 0},
      '{OP_READ,  4095, 32'h0,        1, 1, 32'h0,        ST_OK,    0, 0}
   };

   // Sender: directed table, random batches with clears, then one full-table pass.
   initial begin
      remap_req_type r;
      remap_rsp_type want;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (vectors[i]) begin
         r = '{op: vectors[i].op, id: vectors[i].id[ID_BITS-1:0], val: vectors[i].val,
               kind: vectors[i].kind};
         want = '{new_id: vectors[i].e_id, status: vectors[i].e_st, first: vectors[i].e_first,
                  count: vectors[i].e_cnt[CNT_VAL_W-1:0]};
         send_request(r, vectors[i].typed, want);
      end

      for (int b = 0; b < 10; b++) begin
         // sender stands back until the block has drained
         if (b == 3) begin
            req_valid <= 1'b0;
            wait (pending_rsp.size() == 0);
            @(posedge clock);
         end
         // receiver goes quiet while requests keep coming
         if (b == 1) hold_long = 1'b1;
         send_plain(OP_CLEAR, $urandom_range(0, 4095), $urandom(), 1'($urandom_range(0, 1)));
         random_batch($urandom_range(40, 60));
      end

      // fill to the top with ascending keys so no entry moves, then overflow
      send_plain(OP_CLEAR, 0, 32'h0, 0);
      for (int i = 0; i < TABLE_DEPTH; i++)
         send_plain(OP_LOAD, 4 * i + 1, ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom(),
                    1'($urandom_range(0, 1)));
      for (int i = 0; i < 4; i++)
         send_plain(OP_LOAD, $urandom_range(0, 4095), $urandom(), 1'($urandom_range(0, 1)));
      for (int i = 0; i < 40; i++)
         send_plain(($urandom_range(0, 3) == 0) ? OP_READ : OP_REMAP, $urandom_range(0, 4095),
                    $urandom(), 1'($urandom_range(0, 1)));
      req_valid <= 1'b0;

      wait (pending_rsp.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS sorted_id_remap_table_unit");
      end else begin
         $display("FAIL sorted_id_remap_table_unit");
      end
      $finish;
   end

   // Receiver: random stall before each result, one long hold-off on request.
   initial begin
      int wait_cycles;
      remap_rsp_type exp_rsp;
      forever begin
         wait_cycles = $urandom_range(0, 7);
         if (hold_long) begin
            wait_cycles = 400;
            hold_long = 1'b0;
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid || reset);
         if (pending_rsp.size() == 0) begin
            $error("result with nothing expected: new_id %h status %0d", rsp_new_id, rsp_status);
            error_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_new_id !== exp_rsp.new_id) begin
               $error("new_id expected %h got %h", exp_rsp.new_id, rsp_new_id);
               error_count++;
            end
            if (rsp_status !== exp_rsp.status) begin
               $error("status expected %0d got %0d", exp_rsp.status, rsp_status);
               error_count++;
            end
            if (rsp_first_miss !== exp_rsp.first) begin
               $error("first_miss expected %0d got %0d", exp_rsp.first, rsp_first_miss);
               error_count++;
            end
            if (rsp_miss_count !== exp_rsp.count) begin
               $error("miss_count expected %0d got %0d", exp_rsp.count, rsp_miss_count);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   initial begin
      #(40_000_000);
      $display("FAIL sorted_id_remap_table_unit");
      $finish;
   end

endmodule

/* sorted_id_remap_table_unit.f */
rtl/core/sirt_pkg.sv
rtl/core/sirt_ram.sv
rtl/core/sorted_id_remap_table_unit.sv
bench/tb_sorted_id_remap_table_unit.sv
